// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the lane object counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define LOCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define LOCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/locf_pkg.sv -----
// Types, codes and helper functions of the lane object counter.
package locf_pkg;

    localparam int TIME_W  = 16;
    localparam int COUNT_W = 16;
    localparam int CH_W    = 4;
    localparam int LS_W    = 2;
    localparam int PH_W    = 2;
    localparam int REG_W   = 2;

    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_PROCESS = 1'b1;

    localparam logic [LS_W-1:0] LS_POS = 2'd1;
    localparam logic [LS_W-1:0] LS_NEG = 2'd2;

    localparam logic [REG_W-1:0] REG_FIRST_WAIT = 2'd0;
    localparam logic [REG_W-1:0] REG_CALIB_WAIT = 2'd1;

    localparam logic [TIME_W-1:0] FIRST_WAIT_RST = 16'd800;
    localparam logic [TIME_W-1:0] CALIB_WAIT_RST = 16'd1000;

    localparam logic signed [COUNT_W-1:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [COUNT_W-1:0] COUNT_MIN = 16'sh8000;

    localparam logic [PH_W-1:0] CODE_IDLE   = 2'd0;
    localparam logic [PH_W-1:0] CODE_FIRST  = 2'd1;
    localparam logic [PH_W-1:0] CODE_DECIDE = 2'd2;
    localparam logic [PH_W-1:0] CODE_CALIB  = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_FIRST  = 4'b0010,
        PH_DECIDE = 4'b0100,
        PH_CALIB  = 4'b1000
    } t_phase;

    // Stored state of one lane.
    typedef struct packed {
        t_phase                     phase;
        logic [TIME_W-1:0]          touch;
        logic signed [COUNT_W-1:0]  count;
    } t_lane_st;

    // Update computed for one lane by one process item.
    typedef struct packed {
        t_phase                     phase;
        logic                       stamp;
        logic signed [COUNT_W-1:0]  count;
        logic                       recal;
    } t_lane_upd;

    function automatic logic [PH_W-1:0] phase_code(input t_phase ph);
        logic [PH_W-1:0] code;
        unique case (ph)
            PH_IDLE:   code = CODE_IDLE;
            PH_FIRST:  code = CODE_FIRST;
            PH_DECIDE: code = CODE_DECIDE;
            PH_CALIB:  code = CODE_CALIB;
            default:   code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

// ----- hdl/locf_item_if.sv -----
// Handshake channel that carries input items.
interface locf_item_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [locf_pkg::CH_W-1:0]   channel;
    logic [locf_pkg::LS_W-1:0]   lane_code;

    modport source(output valid, output opcode, output channel, output lane_code,
                   input ready);
    modport sink(input valid, input opcode, input channel, input lane_code,
                 output ready);
endinterface

// ----- hdl/locf_result_if.sv -----
// Handshake channel that carries result items.
interface locf_result_if;
    logic                               valid;
    logic                               ready;
    logic [locf_pkg::CH_W-1:0]          out_channel;
    logic signed [locf_pkg::COUNT_W-1:0] object_count;
    logic [locf_pkg::PH_W-1:0]          detect_state;
    logic                               recalibrate;

    modport source(output valid, output out_channel, output object_count,
                   output detect_state, output recalibrate, input ready);
    modport sink(input valid, input out_channel, input object_count,
                 input detect_state, input recalibrate, output ready);
endinterface

// ----- hdl/locf_cfg_if.sv -----
// Configuration write channel.
interface locf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [locf_pkg::REG_W-1:0]     index;
    logic [locf_pkg::TIME_W-1:0]    data;

    modport source(output valid, output index, output data, input ready);
    modport sink(input valid, input index, input data, output ready);
endinterface

// ----- hdl/locf_lane_step.sv -----
// Next-state logic of one lane for one process item.
module locf_lane_step (
    input  locf_pkg::t_lane_st              i_cur,
    input  logic [locf_pkg::LS_W-1:0]       i_lane_code,
    input  logic [locf_pkg::TIME_W-1:0]     i_ms_time,
    input  logic [locf_pkg::TIME_W-1:0]     i_first_wait,
    input  logic [locf_pkg::TIME_W-1:0]     i_calib_wait,
    output locf_pkg::t_lane_upd             o_upd
);

    logic [locf_pkg::TIME_W-1:0] elapsed;

    // Modular difference, so a wrapped clock still gives the right gap.
    assign elapsed = i_ms_time - i_cur.touch;

    always_comb begin
        o_upd.phase = i_cur.phase;
        o_upd.stamp = 1'b0;
        o_upd.count = i_cur.count;
        o_upd.recal = 1'b0;
        unique case (i_cur.phase)
            locf_pkg::PH_IDLE: begin
                if (i_lane_code == locf_pkg::LS_POS) begin
                    o_upd.stamp = 1'b1;
                    o_upd.phase = locf_pkg::PH_FIRST;
                end
            end
            locf_pkg::PH_FIRST: begin
                if (elapsed > i_first_wait) begin
                    o_upd.phase = locf_pkg::PH_DECIDE;
                end
            end
            locf_pkg::PH_DECIDE: begin
                if (i_lane_code == locf_pkg::LS_POS) begin
                    if (i_cur.count != locf_pkg::COUNT_MAX) begin
                        o_upd.count = i_cur.count + 16'sd1;
                    end
                end else if (i_lane_code == locf_pkg::LS_NEG) begin
                    if (i_cur.count != locf_pkg::COUNT_MIN) begin
                        o_upd.count = i_cur.count - 16'sd1;
                    end
                end
                o_upd.phase = locf_pkg::PH_CALIB;
            end
            locf_pkg::PH_CALIB: begin
                if (elapsed > i_calib_wait) begin
                    o_upd.recal = 1'b1;
                    o_upd.phase = locf_pkg::PH_IDLE;
                end
            end
            default: begin
                o_upd.phase = locf_pkg::PH_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/lane_object_counter_fsm.sv -----
// Top level of the per-channel lane object counter.
// The block takes one item per clock cycle while no process item is stalled. An item is
// registered in the input register and from there either advances the millisecond clock (tick)
// or runs one step of the addressed lane's state machine, whose result is loaded into the output
// register and offered from there. Lane state lives in flip-flops and is read and written in the
// same cycle in which the item is processed, so back-to-back items on the same channel see each
// other's updates. Only a full output register that is not being taken holds up a process item;
// tick items and channels at or beyond NUM_CHANNELS produce no result and never wait.
`include "assert_macros.svh"

module lane_object_counter_fsm #(
    parameter int NUM_CHANNELS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    locf_item_if.sink         i_item,
    locf_cfg_if.sink          i_cfg,
    locf_result_if.source     o_result
);

    // Only channels reachable through the channel field need storage.
    localparam int DEPTH = (NUM_CHANNELS < (1 << locf_pkg::CH_W)) ?
                           NUM_CHANNELS : (1 << locf_pkg::CH_W);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [locf_pkg::CH_W:0] DEPTH_V = (locf_pkg::CH_W + 1)'(DEPTH);

    logic [locf_pkg::TIME_W-1:0] r_first_wait;
    logic [locf_pkg::TIME_W-1:0] r_calib_wait;
    logic [locf_pkg::TIME_W-1:0] r_ms_time;

    locf_pkg::t_phase                   r_phase [DEPTH];
    logic [locf_pkg::TIME_W-1:0]        r_touch [DEPTH];
    logic signed [locf_pkg::COUNT_W-1:0] r_count [DEPTH];

    logic                       r_s1_valid;
    logic                       r_s1_op;
    logic [locf_pkg::CH_W-1:0]  r_s1_ch;
    logic [locf_pkg::LS_W-1:0]  r_s1_ls;

    logic                               r_out_valid;
    logic [locf_pkg::CH_W-1:0]          r_out_ch;
    logic signed [locf_pkg::COUNT_W-1:0] r_out_count;
    logic [locf_pkg::PH_W-1:0]          r_out_state;
    logic                               r_out_recal;

    logic                   s1_in_range;
    logic                   s1_proc;
    logic                   s1_tick;
    logic                   s1_stall;
    logic                   s1_go;
    logic                   item_fire;
    logic [IDX_W-1:0]       s1_idx;
    locf_pkg::t_lane_st     cur_lane;
    locf_pkg::t_lane_upd    lane_upd;

    assign s1_idx      = r_s1_ch[IDX_W-1:0];
    assign s1_in_range = {1'b0, r_s1_ch} < DEPTH_V;
    assign s1_proc     = r_s1_valid && (r_s1_op == locf_pkg::OP_PROCESS) && s1_in_range;
    assign s1_tick     = r_s1_valid && (r_s1_op == locf_pkg::OP_TICK);
    assign s1_stall    = s1_proc && r_out_valid && !o_result.ready;
    assign s1_go       = r_s1_valid && !s1_stall;

    assign i_item.ready = !r_s1_valid || !s1_stall;
    assign item_fire    = i_item.valid && i_item.ready;
    assign i_cfg.ready  = 1'b1;

    assign cur_lane.phase = r_phase[s1_idx];
    assign cur_lane.touch = r_touch[s1_idx];
    assign cur_lane.count = r_count[s1_idx];

    locf_lane_step u_lane_step (
        .i_cur        (cur_lane),
        .i_lane_code  (r_s1_ls),
        .i_ms_time    (r_ms_time),
        .i_first_wait (r_first_wait),
        .i_calib_wait (r_calib_wait),
        .o_upd        (lane_upd)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_wait <= locf_pkg::FIRST_WAIT_RST;
            r_calib_wait <= locf_pkg::CALIB_WAIT_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                locf_pkg::REG_FIRST_WAIT: r_first_wait <= i_cfg.data;
                locf_pkg::REG_CALIB_WAIT: r_calib_wait <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_s1_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_fire) begin
            r_s1_op <= i_item.opcode;
            r_s1_ch <= i_item.channel;
            r_s1_ls <= i_item.lane_code;
        end
    end

    // Millisecond clock and lane state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_time <= '0;
            for (int k = 0; k < DEPTH; k++) begin
                r_phase[k] <= locf_pkg::PH_IDLE;
                r_touch[k] <= '0;
                r_count[k] <= '0;
            end
        end else if (s1_go) begin
            if (s1_tick) begin
                r_ms_time <= r_ms_time + 16'd1;
            end
            if (s1_proc) begin
                r_phase[s1_idx] <= lane_upd.phase;
                r_count[s1_idx] <= lane_upd.count;
                if (lane_upd.stamp) begin
                    r_touch[s1_idx] <= r_ms_time;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_proc) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_proc) begin
            r_out_ch    <= r_s1_ch;
            r_out_count <= lane_upd.count;
            r_out_state <= locf_pkg::phase_code(lane_upd.phase);
            r_out_recal <= lane_upd.recal;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.out_channel  = r_out_ch;
    assign o_result.object_count = r_out_count;
    assign o_result.detect_state = r_out_state;
    assign o_result.recalibrate  = r_out_recal;

    `LOCF_ASSERT_IMP(a_recal_goes_idle, i_clk, i_rst_n,
        r_out_valid && r_out_recal, r_out_state == locf_pkg::CODE_IDLE,
        "recalibrate reported without a return to idle")

    `LOCF_ASSERT_IMP(a_phase_onehot, i_clk, i_rst_n,
        s1_proc, $onehot(cur_lane.phase),
        "lane phase register is not one-hot")

    `LOCF_ASSERT_NXT(a_stall_holds, i_clk, i_rst_n,
        s1_stall, r_s1_valid && $stable(r_s1_ch) && $stable(r_s1_op),
        "stalled input register changed")

    `LOCF_ASSERT_NXT(a_tick_advances, i_clk, i_rst_n,
        s1_tick, r_ms_time == $past(r_ms_time) + 16'd1,
        "tick item did not advance the millisecond clock")

endmodule

// ----- sim/tb_lane_object_counter_fsm.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the lane object counter: directed lane walks, then random traffic.
module tb_lane_object_counter_fsm;

    localparam int NUM_LANES   = 16;
    localparam int SETTLE      = 4;
    localparam int QUIET_LIMIT = 1000;
    localparam int PRINT_CAP   = 40;

    localparam logic [locf_pkg::LS_W-1:0]  LS_NONE      = 2'd0;
    localparam logic [locf_pkg::LS_W-1:0]  LS_SPARE     = 2'd3;
    localparam logic [locf_pkg::REG_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [locf_pkg::REG_W-1:0] REG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [locf_pkg::CH_W-1:0]            channel;
        logic signed [locf_pkg::COUNT_W-1:0]  count;
        logic [locf_pkg::PH_W-1:0]            phase;
        logic                                 recal;
    } t_lane_update;

    logic i_clk;
    logic i_rst_n;

    locf_item_if   item_if();
    locf_cfg_if    cfg_if();
    locf_result_if res_if();

    lane_object_counter_fsm #(
        .NUM_CHANNELS(NUM_LANES)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_if),
        .i_cfg   (cfg_if),
        .o_result(res_if)
    );

    // Predicted state of the counter.
    logic [locf_pkg::TIME_W-1:0]          ms_clock;
    logic [locf_pkg::TIME_W-1:0]          decide_after;
    logic [locf_pkg::TIME_W-1:0]          recal_after;
    logic [locf_pkg::PH_W-1:0]            phase_of   [NUM_LANES];
    logic [locf_pkg::TIME_W-1:0]          touched_at [NUM_LANES];
    logic signed [locf_pkg::COUNT_W-1:0]  count_of   [NUM_LANES];

    t_lane_update lane_updates_due[$];

    int  n_errors;
    int  n_items;
    int  n_updates;
    int  n_recals;
    int  n_clamped;
    int  quiet_cycles;
    bit  src_gaps;
    bit  sink_gaps;
    int  hold_req_id;
    int  hold_req_len;
    int  hold_seen_id;
    int  hold_left;
    int  stall_left;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
    endtask

    // Works out what one accepted item does to the counter and queues the result it causes.
    function automatic void advance_lane_counter(input logic op,
                                                 input logic [locf_pkg::CH_W-1:0] ch,
                                                 input logic [locf_pkg::LS_W-1:0] ls);
        logic [locf_pkg::PH_W-1:0]   ph;
        logic [locf_pkg::TIME_W-1:0] dt;
        logic                        recal;
        t_lane_update                upd;
        if (op == locf_pkg::OP_TICK) begin
            ms_clock = ms_clock + 16'd1;
            return;
        end
        if (ch >= NUM_LANES) return;
        ph    = phase_of[ch];
        dt    = ms_clock - touched_at[ch];
        recal = 1'b0;
        case (ph)
            locf_pkg::CODE_IDLE: begin
                if (ls == locf_pkg::LS_POS) begin
                    touched_at[ch] = ms_clock;
                    ph = locf_pkg::CODE_FIRST;
                end
            end
            locf_pkg::CODE_FIRST: begin
                if (dt > decide_after) ph = locf_pkg::CODE_DECIDE;
            end
            locf_pkg::CODE_DECIDE: begin
                if (ls == locf_pkg::LS_POS) begin
                    if (count_of[ch] != locf_pkg::COUNT_MAX)
                        count_of[ch] = count_of[ch] + 16'sd1;
                    else n_clamped++;
                end else if (ls == locf_pkg::LS_NEG) begin
                    if (count_of[ch] != locf_pkg::COUNT_MIN)
                        count_of[ch] = count_of[ch] - 16'sd1;
                    else n_clamped++;
                end
                ph = locf_pkg::CODE_CALIB;
            end
            default: begin
                if (dt > recal_after) begin
                    recal = 1'b1;
                    ph = locf_pkg::CODE_IDLE;
                end
            end
        endcase
        phase_of[ch] = ph;
        upd.channel = ch;
        upd.count   = count_of[ch];
        upd.phase   = ph;
        upd.recal   = recal;
        lane_updates_due.push_back(upd);
    endfunction

    // Result side: random stalls, plus a long hold-off when a test asks for one.
    always @(posedge i_clk) begin
        if (hold_req_id != hold_seen_id) begin
            hold_seen_id <= hold_req_id;
            hold_left    <= hold_req_len;
            res_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left    <= hold_left - 1;
            res_if.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left   <= stall_left - 1;
            res_if.ready <= 1'b0;
        end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
            stall_left   <= $urandom_range(0, 12);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_lane_update want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            n_updates++;
            if (res_if.recalibrate) n_recals++;
            if (lane_updates_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result on channel %0d",
                                          res_if.out_channel));
            end else begin
                want = lane_updates_due.pop_front();
                if (res_if.out_channel !== want.channel)
                    report_mismatch($sformatf("channel %0d, expected %0d",
                                              res_if.out_channel, want.channel));
                if (res_if.object_count !== want.count)
                    report_mismatch($sformatf("ch %0d count %0d, expected %0d", want.channel,
                                              res_if.object_count, want.count));
                if (res_if.detect_state !== want.phase)
                    report_mismatch($sformatf("ch %0d state %0d, expected %0d", want.channel,
                                              res_if.detect_state, want.phase));
                if (res_if.recalibrate !== want.recal)
                    report_mismatch($sformatf("ch %0d recalibrate %0b, expected %0b",
                                              want.channel, res_if.recalibrate, want.recal));
            end
        end
    end

    // Ends the run if nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic op, input logic [locf_pkg::CH_W-1:0] ch,
                             input logic [locf_pkg::LS_W-1:0] ls);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            item_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        item_if.valid     <= 1'b1;
        item_if.opcode    <= op;
        item_if.channel   <= ch;
        item_if.lane_code <= ls;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        n_items++;
        advance_lane_counter(op, ch, ls);
    endtask

    task automatic send_ticks(input int n);
        for (int k = 0; k < n; k++)
            send_item(locf_pkg::OP_TICK, (locf_pkg::CH_W)'($urandom),
                      (locf_pkg::LS_W)'($urandom));
    endtask

    // Stops sending and waits until every predicted result has come out.
    task automatic wait_idle();
        item_if.valid <= 1'b0;
        while (lane_updates_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [locf_pkg::REG_W-1:0] idx,
                             input logic [locf_pkg::TIME_W-1:0] val);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            locf_pkg::REG_FIRST_WAIT: decide_after = val;
            locf_pkg::REG_CALIB_WAIT: recal_after  = val;
            default: ;
        endcase
    endtask

    function automatic logic [locf_pkg::LS_W-1:0] pick_lane_code();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return locf_pkg::LS_POS;
        if (r < 8) return locf_pkg::LS_NEG;
        return (locf_pkg::LS_W)'($urandom);
    endfunction

    task automatic test_reset_defaults();
        src_gaps   = 1'b1;
        sink_gaps <= 1'b1;
        send_item(locf_pkg::OP_PROCESS, 4'd0, locf_pkg::LS_POS);
        send_ticks(800);
        // Exactly at the first threshold: no move.
        send_item(locf_pkg::OP_PROCESS, 4'd0, locf_pkg::LS_NEG);
        send_ticks(1);
        send_item(locf_pkg::OP_PROCESS, 4'd0, locf_pkg::LS_POS);
        send_item(locf_pkg::OP_PROCESS, 4'd0, locf_pkg::LS_POS);
    endtask

    task automatic test_registers_and_lanes();
        write_reg(locf_pkg::REG_FIRST_WAIT, 16'd0);
        write_reg(locf_pkg::REG_CALIB_WAIT, 16'd0);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'hFFFF);
        // A negative detect or an idle lane code leaves an idle lane where it is.
        send_item(locf_pkg::OP_PROCESS, 4'd1, locf_pkg::LS_NEG);
        send_item(locf_pkg::OP_PROCESS, 4'd1, LS_NONE);
        send_item(locf_pkg::OP_PROCESS, 4'd1, LS_SPARE);
        send_item(locf_pkg::OP_PROCESS, 4'd1, locf_pkg::LS_POS);
        send_item(locf_pkg::OP_PROCESS, 4'd1, locf_pkg::LS_POS);
        send_ticks(1);
        send_item(locf_pkg::OP_PROCESS, 4'd1, LS_NONE);
        send_item(locf_pkg::OP_PROCESS, 4'd1, LS_SPARE);
        send_item(locf_pkg::OP_PROCESS, 4'd1, locf_pkg::LS_POS);
        send_item(locf_pkg::OP_PROCESS, 4'd15, locf_pkg::LS_POS);
        send_ticks(1);
        send_item(locf_pkg::OP_PROCESS, 4'd15, LS_NONE);
        send_item(locf_pkg::OP_PROCESS, 4'd15, locf_pkg::LS_NEG);
        send_item(locf_pkg::OP_PROCESS, 4'd15, locf_pkg::LS_POS);
        // With the widest thresholds a lane can never leave its wait state.
        write_reg(locf_pkg::REG_FIRST_WAIT, 16'hFFFF);
        send_item(locf_pkg::OP_PROCESS, 4'd2, locf_pkg::LS_POS);
        send_ticks(3);
        send_item(locf_pkg::OP_PROCESS, 4'd2, locf_pkg::LS_POS);
        write_reg(locf_pkg::REG_FIRST_WAIT, 16'd0);
        send_item(locf_pkg::OP_PROCESS, 4'd2, LS_NONE);
        send_item(locf_pkg::OP_PROCESS, 4'd2, locf_pkg::LS_POS);
        write_reg(locf_pkg::REG_CALIB_WAIT, 16'hFFFF);
        send_ticks(2);
        send_item(locf_pkg::OP_PROCESS, 4'd2, locf_pkg::LS_POS);
        write_reg(locf_pkg::REG_CALIB_WAIT, 16'd0);
        send_item(locf_pkg::OP_PROCESS, 4'd2, LS_NONE);
        for (int ch = 0; ch < NUM_LANES; ch++) begin
            send_item(locf_pkg::OP_PROCESS, (locf_pkg::CH_W)'(ch), (locf_pkg::LS_W)'(ch));
        end
    endtask

    task automatic test_short_thresholds();
        src_gaps   = 1'b0;
        sink_gaps <= 1'b0;
        write_reg(locf_pkg::REG_FIRST_WAIT, 16'd3);
        write_reg(locf_pkg::REG_CALIB_WAIT, 16'd5);
        send_item(locf_pkg::OP_PROCESS, 4'd3, locf_pkg::LS_POS);
        send_ticks(3);
        // Exactly at the first threshold: no move.
        send_item(locf_pkg::OP_PROCESS, 4'd3, LS_NONE);
        send_ticks(1);
        send_item(locf_pkg::OP_PROCESS, 4'd3, LS_NONE);
        send_item(locf_pkg::OP_PROCESS, 4'd3, locf_pkg::LS_POS);
        send_ticks(1);
        send_item(locf_pkg::OP_PROCESS, 4'd3, LS_NONE);
        send_ticks(1);
        send_item(locf_pkg::OP_PROCESS, 4'd3, LS_NONE);
    endtask

    task automatic test_backpressure();
        src_gaps   = 1'b1;
        sink_gaps <= 1'b1;
        write_reg(locf_pkg::REG_FIRST_WAIT, 16'd1);
        write_reg(locf_pkg::REG_CALIB_WAIT, 16'd2);
        hold_req_len <= 80;
        hold_req_id  <= hold_req_id + 1;
        for (int k = 0; k < 40; k++) begin
            if (k % 5 == 4) send_ticks(1);
            else send_item(locf_pkg::OP_PROCESS, (locf_pkg::CH_W)'($urandom_range(0, 3)),
                           pick_lane_code());
        end
        wait_idle();
    endtask

    // Mostly well-formed lane traffic on the first busy_lanes channels, with some noise.
    task automatic run_random_phase(input int n, input int busy_lanes);
        int pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) send_ticks(1);
            else if (pick < 90)
                send_item(locf_pkg::OP_PROCESS,
                          (locf_pkg::CH_W)'($urandom_range(0, busy_lanes - 1)),
                          pick_lane_code());
            else
                send_item(locf_pkg::OP_PROCESS, (locf_pkg::CH_W)'($urandom),
                          (locf_pkg::LS_W)'($urandom));
        end
    endtask

    task automatic test_random();
        write_reg(locf_pkg::REG_FIRST_WAIT, 16'd2);
        write_reg(locf_pkg::REG_CALIB_WAIT, 16'd4);
        run_random_phase(25, 4);
        write_reg(locf_pkg::REG_FIRST_WAIT, (locf_pkg::TIME_W)'($urandom_range(0, 5)));
        write_reg(locf_pkg::REG_CALIB_WAIT, (locf_pkg::TIME_W)'($urandom_range(0, 8)));
        run_random_phase(20, 8);
        write_reg(locf_pkg::REG_FIRST_WAIT, 16'd0);
        write_reg(locf_pkg::REG_CALIB_WAIT, 16'd0);
        run_random_phase(20, NUM_LANES);
        // Final stretch runs with both sides always willing.
        src_gaps   = 1'b0;
        sink_gaps <= 1'b0;
        write_reg(locf_pkg::REG_FIRST_WAIT, (locf_pkg::TIME_W)'($urandom_range(0, 3)));
        write_reg(locf_pkg::REG_CALIB_WAIT, (locf_pkg::TIME_W)'($urandom_range(0, 6)));
        run_random_phase(25, 6);
    endtask

    initial begin
        i_rst_n            = 1'b0;
        item_if.valid      = 1'b0;
        item_if.opcode     = locf_pkg::OP_TICK;
        item_if.channel    = '0;
        item_if.lane_code  = LS_NONE;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = locf_pkg::REG_FIRST_WAIT;
        cfg_if.data        = '0;
        res_if.ready       = 1'b0;
        src_gaps           = 1'b0;
        sink_gaps          = 1'b0;
        hold_req_id        = 0;
        hold_req_len       = 0;
        hold_seen_id       = 0;
        hold_left          = 0;
        stall_left         = 0;
        quiet_cycles       = 0;
        n_errors           = 0;
        n_items            = 0;
        n_updates          = 0;
        n_recals           = 0;
        n_clamped          = 0;
        ms_clock           = '0;
        decide_after       = locf_pkg::FIRST_WAIT_RST;
        recal_after        = locf_pkg::CALIB_WAIT_RST;
        for (int ch = 0; ch < NUM_LANES; ch++) begin
            phase_of[ch]   = locf_pkg::CODE_IDLE;
            touched_at[ch] = '0;
            count_of[ch]   = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_registers_and_lanes();
        test_short_thresholds();
        test_backpressure();
        test_random();
        wait_idle();

        if (lane_updates_due.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", lane_updates_due.size()));
        $display("Ran %0d items through the counter and checked %0d lane results.",
                 n_items, n_updates);
        $display("Seen: %0d recalibrations, %0d clamped count steps, %0d mismatches.",
                 n_recals, n_clamped, n_errors);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
